[hw/rtl/cdq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque unit
// Depth, index width, opcodes, status codes, controller states and the
// command/status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Storage geometry
  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WORD_W = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef logic [IDX_W-1:0] cdq_idx_t;

  // Input opcodes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } cdq_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_POP  = 2'd1,
    S_LIST = 2'd2
  } cdq_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic        push_front;
    logic        push_rear;
    logic        pop_front;
    logic        pop_rear;
    logic        list_start;
    logic        list_step;
    logic        out_load;
    logic        out_from_mem;
    cdq_status_t out_status;
    logic        out_last;
  } cdq_cmd_t;

  // Datapath to controller flags
  typedef struct packed {
    logic empty;
    logic full;
    logic list_end;
  } cdq_flags_t;

  // Advance an index with wrap
  function automatic cdq_idx_t wrap_inc(input cdq_idx_t i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  // Step an index back with wrap
  function automatic cdq_idx_t wrap_dec(input cdq_idx_t i);
    return (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cdq_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_if: valid/ready channels of the circular deque unit
// Request channel carries opcode and word; result channel carries the
// returned word, status and the end-of-response flag.
// ----------------------------------------------------------------------------
interface cdq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic signed [31:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface cdq_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] data_out;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output data_out, output status, output last, input ready);
  modport sink   (input valid, input data_out, input status, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/cdq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_datapath: word store, front/rear indices and result register
// Executes controller commands: writes pushes, reads pops and list walks
// through a registered-read memory, and loads the outgoing result beat.
// ----------------------------------------------------------------------------
module cdq_datapath
  import cdq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cdq_cmd_t           cmd,
  input  wire logic [WORD_W-1:0]  wr_data,
  output      cdq_flags_t         flags,
  output      logic [WORD_W-1:0]  out_data,
  output      logic [1:0]         out_status,
  output      logic               out_last
);

  logic [WORD_W-1:0] mem [DEPTH];

  cdq_idx_t head_r, head_nxt;
  cdq_idx_t tail_r, tail_nxt;
  logic     empty_r, empty_nxt;
  cdq_idx_t list_ptr_r, list_ptr_nxt;

  logic              wr_en;
  cdq_idx_t          wr_addr;
  logic              rd_en;
  cdq_idx_t          rd_addr;
  logic [WORD_W-1:0] rd_data_r;

  logic [WORD_W-1:0] out_data_r;
  cdq_status_t       out_status_r;
  logic              out_last_r;

  // Status flags for the controller
  assign flags.empty    = empty_r;
  assign flags.full     = !empty_r && (wrap_inc(tail_r) == head_r);
  assign flags.list_end = (list_ptr_r == tail_r);

  // Write port: a push into an empty store restarts at entry zero
  assign wr_en = cmd.push_front || cmd.push_rear;
  always_comb begin
    if (empty_r) begin
      wr_addr = '0;
    end else if (cmd.push_front) begin
      wr_addr = wrap_dec(head_r);
    end else begin
      wr_addr = wrap_inc(tail_r);
    end
  end

  // Read port: front, rear or next list position
  assign rd_en = cmd.pop_front || cmd.pop_rear || cmd.list_start || cmd.list_step;
  always_comb begin
    if (cmd.pop_rear) begin
      rd_addr = tail_r;
    end else if (cmd.list_step) begin
      rd_addr = wrap_inc(list_ptr_r);
    end else begin
      rd_addr = head_r;
    end
  end

  // Next index state
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    empty_nxt    = empty_r;
    list_ptr_nxt = list_ptr_r;
    if (wr_en) begin
      if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
      end else if (cmd.push_front) begin
        head_nxt = wrap_dec(head_r);
      end else begin
        tail_nxt = wrap_inc(tail_r);
      end
    end else if (cmd.pop_front || cmd.pop_rear) begin
      if (head_r == tail_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b1;
      end else if (cmd.pop_front) begin
        head_nxt = wrap_inc(head_r);
      end else begin
        tail_nxt = wrap_dec(tail_r);
      end
    end
    if (cmd.list_start) begin
      list_ptr_nxt = head_r;
    end else if (cmd.list_step) begin
      list_ptr_nxt = wrap_inc(list_ptr_r);
    end
  end

  // Hold indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      empty_r    <= 1'b1;
      list_ptr_r <= '0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      empty_r    <= empty_nxt;
      list_ptr_r <= list_ptr_nxt;
    end
  end

  // Word store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r   <= cmd.out_from_mem ? rd_data_r : '0;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

[hw/rtl/cdq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl: request sequencer for the circular deque unit
// Decodes each request, issues datapath commands, walks list responses one
// word per beat and owns the result valid flag.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [2:0]  in_opcode,
  output      logic        in_ready,
  output      logic        out_valid,
  input  wire logic        out_ready,
  input  wire cdq_flags_t  flags,
  output      cdq_cmd_t    cmd
);

  cdq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  // Result register can take a beat when empty or draining
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt        = state_r;
    cmd              = '0;
    cmd.out_status   = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (cdq_op_t'(in_opcode))
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (flags.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.push_front = (cdq_op_t'(in_opcode) == OP_PUSH_FRONT);
                cmd.push_rear  = (cdq_op_t'(in_opcode) == OP_PUSH_REAR);
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (flags.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.pop_front = (cdq_op_t'(in_opcode) == OP_POP_FRONT);
                cmd.pop_rear  = (cdq_op_t'(in_opcode) == OP_POP_REAR);
                state_nxt     = S_POP;
              end
            end
            OP_LIST: begin
              if (flags.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
                state_nxt      = S_LIST;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = flags.list_end;
          if (flags.list_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.list_step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Track result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Never overwrite an undelivered beat
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result beat overwritten before delivery");

  // Never push into a full store
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_rear) |-> !flags.full)
    else $error("push issued on full store");

  // Never walk past the rear word
  a_step_before_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.list_step |-> !flags.list_end)
    else $error("list walk stepped past rear");

  // A pop on a non-empty store moves to the read-wait state
  a_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_front || cmd.pop_rear) |=> (state_r == S_POP))
    else $error("pop did not enter read wait");

endmodule
`default_nettype wire

[hw/rtl/circular_deque_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit: circular double-ended queue of signed 32-bit words
// Push/pop at either end, or list all words front to rear, over valid/ready
// channels. Full and empty conditions are reported in the result status.
// ----------------------------------------------------------------------------
//
//   channel   direction   beat contents
//   -------   ---------   ------------------------------------------
//   in_if     sink        opcode, data_in
//   out_if    source      data_out, status, last
//
// Push, error and unused-opcode requests: result loaded at accept.
// Pop: the result is loaded from the registered read port of the word store.
// List of N words: one store read per result beat.
// Reset (rst_n low, synchronous) empties the deque; the store needs no clearing.
// in_if.ready is low while a pop or list is in progress, or while an
// undelivered result sits in the output register and out_if.ready is low.
// ----------------------------------------------------------------------------
module circular_deque_unit
  import cdq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  cdq_in_if.sink   in_if,
  cdq_out_if.source out_if
);

  cdq_cmd_t          cmd;
  cdq_flags_t        flags;
  logic [WORD_W-1:0] out_data;
  logic [1:0]        out_status;
  logic              out_last;
  logic              in_ready;
  logic              out_valid;

  // Sequencer
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // Store and result register
  cdq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .wr_data    (in_if.data_in),
    .flags      (flags),
    .out_data   (out_data),
    .out_status (out_status),
    .out_last   (out_last)
  );

  // Drive channel ports
  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid;
  assign out_if.data_out = out_data;
  assign out_if.status   = out_status;
  assign out_if.last     = out_last;

endmodule
`default_nettype wire

[verif/tb_circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// tb_circular_deque_unit: self-checking bench for the circular deque unit
// Sends directed and random deque requests over the request channel, keeps a
// shadow deque that predicts every result beat, and checks each beat on the
// result channel in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_circular_deque_unit;
  import cdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 475;
  localparam int CALM_FIRST     = 200;
  localparam int CALM_LAST      = 300;
  localparam int IDLE_PCT       = 33;

  // Opcodes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]         opcode;
    logic signed [31:0] word;
  } deque_req_t;

  typedef struct {
    logic signed [31:0] word;
    cdq_status_t        status;
    logic               last;
  } deque_reply_t;

  logic clk;
  logic rst_n;

  cdq_in_if  in_if ();
  cdq_out_if out_if ();

  circular_deque_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Shadow deque
  logic signed [31:0] dq_store [DEPTH];
  cdq_idx_t           dq_head;
  cdq_idx_t           dq_tail;
  logic               dq_empty;

  deque_req_t   pending_reqs [$];
  deque_reply_t deque_replies [$];

  int req_issued;
  int req_accepted;
  int beats_checked;
  int errors;
  int idle_cycles;
  int n_total;
  int n_push, n_pop, n_list, n_full, n_empty;

  // --------------------------------------------------------------------------
  // Shadow deque model
  // --------------------------------------------------------------------------
  function automatic cdq_idx_t next_idx(input cdq_idx_t i);
    return cdq_idx_t'((int'(i) + 1) % DEPTH);
  endfunction

  function automatic cdq_idx_t prev_idx(input cdq_idx_t i);
    return cdq_idx_t'((int'(i) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic void post_reply(input logic signed [31:0] word,
                                     input cdq_status_t status, input logic last);
    deque_reply_t r;
    r.word   = word;
    r.status = status;
    r.last   = last;
    deque_replies.push_back(r);
  endfunction

  // Update the shadow deque for one request and queue the beats it owes
  function automatic void apply_deque_op(input logic [2:0] op,
                                         input logic signed [31:0] word);
    cdq_idx_t idx;
    logic     done;
    int       n;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        n_push++;
        if (!dq_empty && next_idx(dq_tail) == dq_head) begin
          n_full++;
          post_reply('0, ST_FULL, 1'b1);
        end else begin
          if (dq_empty) begin
            dq_head     = '0;
            dq_tail     = '0;
            dq_empty    = 1'b0;
            dq_store[0] = word;
          end else if (op == OP_PUSH_FRONT) begin
            dq_head           = prev_idx(dq_head);
            dq_store[dq_head] = word;
          end else begin
            dq_tail           = next_idx(dq_tail);
            dq_store[dq_tail] = word;
          end
          post_reply('0, ST_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        n_pop++;
        if (dq_empty) begin
          n_empty++;
          post_reply('0, ST_EMPTY, 1'b1);
        end else begin
          post_reply(dq_store[(op == OP_POP_FRONT) ? dq_head : dq_tail], ST_OK, 1'b1);
          if (dq_head == dq_tail) begin
            dq_head  = '0;
            dq_tail  = '0;
            dq_empty = 1'b1;
          end else if (op == OP_POP_FRONT) begin
            dq_head = next_idx(dq_head);
          end else begin
            dq_tail = prev_idx(dq_tail);
          end
        end
      end
      OP_LIST: begin
        n_list++;
        if (dq_empty) begin
          n_empty++;
          post_reply('0, ST_EMPTY, 1'b1);
        end else begin
          // Walk front to rear, flag the rear word
          idx  = dq_head;
          done = 1'b0;
          for (n = 0; n < DEPTH && !done; n++) begin
            done = (idx == dq_tail) || (n == DEPTH - 1);
            post_reply(dq_store[idx], ST_OK, done);
            idx = next_idx(idx);
          end
        end
      end
      default: begin
        post_reply('0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_req(input logic [2:0] op, input logic signed [31:0] word);
    deque_req_t r;
    r.opcode = op;
    r.word   = word;
    pending_reqs.push_back(r);
  endfunction

  // Random word, leaning on the extremes now and then
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Random request; fill-leaning or drain-leaning so both full and empty get hit
  function automatic void queue_random(input logic fill_phase);
    int r;
    r = $urandom_range(99);
    if (r < 2) begin
      queue_req(3'($urandom_range(5, 7)), pick_word());
    end else if (r < (fill_phase ? 62 : 27)) begin
      queue_req($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_word());
    end else if (r < 88) begin
      queue_req($urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR, pick_word());
    end else begin
      queue_req(OP_LIST, pick_word());
    end
  endfunction

  function automatic logic calm_window();
    return (req_accepted >= CALM_FIRST) && (req_accepted < CALM_LAST);
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request driver: present the next beat once the previous one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    deque_req_t nxt;
    logic       go;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (req_accepted == req_issued) begin
      go = (pending_reqs.size() > 0) &&
           (calm_window() || $urandom_range(99) >= IDLE_PCT);
      if (go) begin
        nxt = pending_reqs.pop_front();
        in_if.valid   <= 1'b1;
        in_if.opcode  <= nxt.opcode;
        in_if.data_in <= nxt.word;
        req_issued++;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall at random, hold ready high through the calm stretch
  always @(negedge clk) begin
    out_if.ready <= rst_n && (calm_window() || $urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on request beats, check result beats in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    deque_reply_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        apply_deque_op(in_if.opcode, in_if.data_in);
        req_accepted <= req_accepted + 1;
      end
      if (out_if.valid && out_if.ready) begin
        beats_checked <= beats_checked + 1;
        if (deque_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat data_out=%0d status=%0d last=%0b",
                   $time, out_if.data_out, out_if.status, out_if.last);
        end else begin
          want = deque_replies.pop_front();
          if (out_if.data_out !== want.word) begin
            errors++;
            $display("%0t: data_out mismatch expected %0d actual %0d",
                     $time, want.word, out_if.data_out);
          end
          if (out_if.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, want.status, out_if.status);
          end
          if (out_if.last !== want.last) begin
            errors++;
            $display("%0t: last mismatch expected %0b actual %0b",
                     $time, want.last, out_if.last);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL circular_deque_unit");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, build the request list, wait for the drain, report
  // --------------------------------------------------------------------------
  initial begin
    logic fill_phase;
    int   i;

    in_if.valid   = 1'b0;
    in_if.opcode  = '0;
    in_if.data_in = '0;
    out_if.ready  = 1'b0;
    rst_n         = 1'b0;
    dq_head       = '0;
    dq_tail       = '0;
    dq_empty      = 1'b1;
    req_issued    = 0;
    req_accepted  = 0;
    beats_checked = 0;
    errors        = 0;
    idle_cycles   = 0;
    n_push = 0; n_pop = 0; n_list = 0; n_full = 0; n_empty = 0;

    // Directed: empty errors, fill to full, overflow, list, spare opcodes, drain
    queue_req(OP_LIST,       32'sh1234_5678);
    queue_req(OP_POP_FRONT,  '0);
    queue_req(OP_POP_REAR,   '0);
    queue_req(OP_PUSH_FRONT, 32'sh8000_0000);
    queue_req(OP_PUSH_REAR,  32'sh7FFF_FFFF);
    queue_req(OP_PUSH_FRONT, -32'sd1);
    queue_req(OP_PUSH_REAR,  '0);
    queue_req(OP_PUSH_FRONT, 32'sh5555_5555);
    queue_req(OP_PUSH_REAR,  32'shAAAA_AAAA);
    queue_req(OP_PUSH_FRONT, 32'sd1);
    queue_req(OP_PUSH_REAR,  -32'sd2);
    queue_req(OP_PUSH_FRONT, 32'sh0BAD_F00D);
    queue_req(OP_PUSH_REAR,  32'sh0BAD_F00D);
    queue_req(OP_LIST,       '0);
    queue_req(OP_SPARE_5,    -32'sd1);
    queue_req(OP_SPARE_6,    32'sh5555_5555);
    queue_req(OP_SPARE_7,    32'shAAAA_AAAA);
    queue_req(OP_POP_FRONT,  '0);
    queue_req(OP_POP_REAR,   '0);
    queue_req(OP_LIST,       '0);
    for (i = 0; i < 5; i++) queue_req(OP_POP_FRONT, '0);
    queue_req(OP_POP_REAR,   '0);

    // Random: alternate fill-leaning and drain-leaning stretches
    fill_phase = 1'b1;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) fill_phase = ~fill_phase;
      queue_random(fill_phase);
    end
    n_total = pending_reqs.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (!(req_accepted == n_total && deque_replies.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d pushes (%0d hit full), %0d pops, %0d lists",
             req_accepted, n_push, n_full, n_pop, n_list);
    $display("Checked %0d result beats, %0d empty-deque rejects", beats_checked, n_empty);
    if (errors == 0) begin
      $display("PASS circular_deque_unit");
    end else begin
      $display("FAIL circular_deque_unit");
    end
    $finish;
  end

endmodule
